[rtl/sorted_array_table_defines.svh]
// Assertion macros used by the file that checks this block.
`ifndef SORTED_ARRAY_TABLE_DEFINES_SVH
`define SORTED_ARRAY_TABLE_DEFINES_SVH

// Check that a condition holds at every edge out of reset.
`define SAT_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("sorted array table check failed");

// Check that a trigger implies a consequence in the following cycle.
`define SAT_ASSERT_NEXT(label, clk, rst, trig, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) \
      else $error("sorted array table check failed");

`endif

[rtl/sat_pkg.sv]
package sat_pkg;

   localparam int DEPTH     = 64;
   localparam int KEY_WIDTH = 32;
   localparam int IDX_W     = $clog2(DEPTH);
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int CAP_W     = 7;
   localparam int CMD_W     = 2;
   localparam int STS_W     = 2;

   typedef logic [KEY_WIDTH-1:0] key_type;
   typedef logic [IDX_W-1:0]     idx_type;
   typedef logic [CNT_W-1:0]     cnt_type;
   typedef logic [CAP_W-1:0]     cap_type;
   typedef logic [CMD_W-1:0]     cmd_type;

   localparam cmd_type CMD_INSERT = 2'd0;
   localparam cmd_type CMD_LOOKUP = 2'd1;
   localparam cmd_type CMD_REMOVE = 2'd2;

   typedef enum logic [STS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   localparam cap_type CAP_RESET = 7'd64;

   // Operation broadcast to every cell of the row.
   typedef struct packed {
      logic    ins_en;
      logic    rem_en;
      key_type key;
      idx_type idx;
   } op_type;

endpackage

[rtl/sorted_array_table.sv]
// Channel | Direction | Ports
// req     | in        | req_valid, req_ready, req_cmd, req_key_in, req_position
// rsp     | out       | rsp_valid, rsp_ready, rsp_key_out, rsp_occupancy, rsp_status
// csr     | in        | csr_valid, csr_ready, csr_capacity_limit
//
// Every operation finishes in the cycle it is accepted: the cell row compares,
// shifts and reads in one step, and the result lands in the output register.
// A new beat is taken each cycle while the output register is empty or drains.
// Synchronous reset empties the table and sets the capacity limit to 64.
// A stalled result holds the request side only until rsp_ready returns.
`include "sorted_array_table_defines.svh"

module sorted_array_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sat_pkg::cmd_type req_cmd,
   input  sat_pkg::key_type req_key_in,
   input  sat_pkg::idx_type req_position,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sat_pkg::key_type rsp_key_out,
   output sat_pkg::cnt_type rsp_occupancy,
   output logic [1:0]       rsp_status,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  sat_pkg::cap_type csr_capacity_limit
);
   import sat_pkg::*;

   localparam int CMP_W = CNT_W + CAP_W;

   cnt_type    count_ff;
   cnt_type    count_in;
   cap_type    cap_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   key_type    rsp_key_ff;
   key_type    rsp_key_in;
   cnt_type    rsp_occ_ff;
   status_type rsp_sts_ff;
   status_type rsp_sts_in;
   logic       accept;
   logic       full;
   logic       in_range;
   op_type     op;
   key_type    read_key;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Decode the beat against count and capacity
   assign full = (CMP_W'(count_ff) >= CMP_W'(cap_ff)) ||
                 (CMP_W'(count_ff) >= CMP_W'(DEPTH));
   assign in_range = CNT_W'(req_position) < count_ff;

   always_comb begin
      op         = '0;
      op.key     = req_key_in;
      op.idx     = req_position;
      count_in   = count_ff;
      rsp_key_in = '0;
      rsp_sts_in = ST_OK;
      case (req_cmd)
         CMD_INSERT: begin
            if (full) begin
               rsp_sts_in = ST_FULL;
            end else begin
               op.ins_en = accept;
               count_in  = count_ff + CNT_W'(1);
            end
         end
         CMD_LOOKUP: begin
            if (in_range) begin
               rsp_key_in = read_key;
            end else begin
               rsp_sts_in = ST_RANGE;
            end
         end
         CMD_REMOVE: begin
            if (in_range) begin
               op.rem_en = accept;
               count_in  = count_ff - CNT_W'(1);
            end else begin
               rsp_sts_in = ST_RANGE;
            end
         end
         default: begin
         end
      endcase
   end

   sat_row u_row (
      .clock    (clock),
      .count    (count_ff),
      .op       (op),
      .read_key (read_key)
   );

   // Advance count and the valid flag on accept, drop valid when taken
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_capacity_limit;
         end
      end
   end

   // Hold the result payload until the next accepted beat
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_key_ff <= rsp_key_in;
         rsp_occ_ff <= count_in;
         rsp_sts_ff <= rsp_sts_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_key_out   = rsp_key_ff;
   assign rsp_occupancy = rsp_occ_ff;
   assign rsp_status    = STS_W'(rsp_sts_ff);

   `SAT_ASSERT_ALWAYS(a_count_bound, clock, reset, CMP_W'(count_ff) <= CMP_W'(DEPTH))
   `SAT_ASSERT_NEXT(a_insert_grows, clock, reset, accept && op.ins_en, count_ff == $past(count_ff) + CNT_W'(1))
   `SAT_ASSERT_NEXT(a_remove_shrinks, clock, reset, accept && op.rem_en, count_ff == $past(count_ff) - CNT_W'(1))
   `SAT_ASSERT_ALWAYS(a_error_no_key, clock, reset, !(rsp_valid_ff && rsp_sts_ff != ST_OK) || rsp_key_ff == '0)

endmodule

[rtl/sat_cell.sv]
module sat_cell (
   input  logic            clock,
   input  sat_pkg::idx_type cell_idx,
   input  sat_pkg::cnt_type count,
   input  sat_pkg::op_type  op,
   input  logic            prev_lt,
   input  sat_pkg::key_type prev_key,
   input  sat_pkg::key_type next_key,
   output logic            lt,
   output sat_pkg::key_type key,
   output sat_pkg::key_type read_key
);
   import sat_pkg::*;

   key_type key_ff;
   key_type key_in;
   logic    occupied;

   // Flag a stored key strictly below the new key
   assign occupied = CNT_W'(cell_idx) < count;
   assign lt       = occupied && (key_ff < op.key);

   // Shift up past the slot, take the new key at the slot, shift down on remove
   always_comb begin
      key_in = key_ff;
      if (op.ins_en) begin
         if (!prev_lt) begin
            key_in = prev_key;
         end else if (!lt) begin
            key_in = op.key;
         end
      end else if (op.rem_en) begin
         if (cell_idx >= op.idx) begin
            key_in = next_key;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key      = key_ff;
   assign read_key = (cell_idx == op.idx) ? key_ff : '0;

endmodule

[rtl/sat_row.sv]
module sat_row (
   input  logic            clock,
   input  sat_pkg::cnt_type count,
   input  sat_pkg::op_type  op,
   output sat_pkg::key_type read_key
);
   import sat_pkg::*;

   logic    lt_w   [DEPTH];
   key_type key_w  [DEPTH];
   key_type read_w [DEPTH];

   // Build the chain: each cell sees its left and right neighbor
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic    prev_lt_w;
      key_type prev_key_w;
      key_type next_key_w;

      if (i == 0) begin : g_first
         assign prev_lt_w  = 1'b1;
         assign prev_key_w = key_w[i];
      end else begin : g_mid
         assign prev_lt_w  = lt_w[i-1];
         assign prev_key_w = key_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign next_key_w = key_w[i];
      end else begin : g_inner
         assign next_key_w = key_w[i+1];
      end

      sat_cell u_cell (
         .clock    (clock),
         .cell_idx (IDX_W'(i)),
         .count    (count),
         .op       (op),
         .prev_lt  (prev_lt_w),
         .prev_key (prev_key_w),
         .next_key (next_key_w),
         .lt       (lt_w[i]),
         .key      (key_w[i]),
         .read_key (read_w[i])
      );
   end

   // Merge the one selected cell onto the read bus
   always_comb begin
      read_key = '0;
      for (int i = 0; i < DEPTH; i++) begin
         read_key = read_key | read_w[i];
      end
   end

endmodule
